// ===== rtl/lifo_stack_engine_defines.svh =====
// Assertion macros shared by the LIFO stack engine RTL.
`ifndef LIFO_STACK_ENGINE_DEFINES_SVH
`define LIFO_STACK_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside of reset.
`define LSE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside of reset.
`define LSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lse_pkg.sv =====
// Types, codes and constants of the LIFO stack engine.
package lse_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int WORD_W          = 32;

   typedef enum logic [2:0] {
      MODE_PUSH = 3'd0,
      MODE_DUMP = 3'd1,
      MODE_PEEK = 3'd2,
      MODE_POP  = 3'd3,
      MODE_SWAP = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_ARG    = 3'd1,
      STATUS_PEEK_EMPTY = 3'd2,
      STATUS_POP_EMPTY  = 3'd3,
      STATUS_SWAP_SHORT = 3'd4,
      STATUS_OVERFLOW   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PEEK,
      ST_DUMP,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_SWAP_C
   } state_type;

   typedef struct packed {
      logic [2:0]               mode;
      logic signed [WORD_W-1:0] push_value;
      logic                     arg_ok;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] out_value;
      logic [2:0]               status;
      logic                     last;
   } rsp_type;

endpackage

// ===== rtl/lifo_stack_engine.sv =====
// Top level of the LIFO stack engine: command decode, stack memory and result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  request | in        | start high and busy low    | req_item  (mode, push_value, arg_ok)
//  result  | out       | rsp_strobe, one cycle each | rsp_item  (out_value, status, last)
//
// Push, pop and every error transaction finish while busy stays low throughout.
// Peek of a non-empty stack, swap of two or more entries and a dump of a non-empty stack
// pass through ST_PEEK, ST_SWAP_A to ST_SWAP_C or ST_DUMP with busy high, as set by the
// single stack memory with its registered read and one write port.
// Each result leaves the result register in the cycle after the one that forms it; the
// receiver cannot stall it. Reset clears the entry count and returns the controller to
// idle; the memory keeps its contents, and only entries below the count are ever used.
module lifo_stack_engine #(
   parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  lse_pkg::req_type req_item,
   output logic            rsp_strobe,
   output lse_pkg::rsp_type rsp_item
);
   import lse_pkg::*;

`include "lifo_stack_engine_defines.svh"

   localparam int CntW  = $clog2(STACK_DEPTH + 1);
   localparam int AddrW = $clog2(STACK_DEPTH);

   // Controller and stack bookkeeping.
   state_type            state_ff, state_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [AddrW-1:0]     idx_ff, idx_in;
   logic [WORD_W-1:0]    top_ff, top_in;

   // Result register.
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_item_ff, rsp_item_in;

   // Stack memory: one write and one registered read per cycle.
   logic [WORD_W-1:0]    stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0]    rd_data_ff;
   logic [AddrW-1:0]     mem_raddr;
   logic [AddrW-1:0]     mem_waddr;
   logic [WORD_W-1:0]    mem_wdata;
   logic                 mem_we;

   // Decoded stack conditions.
   logic                 accept;
   logic                 cnt_empty;
   logic                 cnt_full;
   logic                 cnt_short;
   logic [CntW-1:0]      cnt_m1;
   logic [CntW-1:0]      cnt_m2;
   logic [AddrW-1:0]     top_addr;
   logic [AddrW-1:0]     below_addr;
   logic [AddrW-1:0]     idx_m1;

   assign accept     = start && (state_ff == ST_IDLE);
   assign cnt_empty  = (count_ff == '0);
   assign cnt_full   = (count_ff == CntW'(STACK_DEPTH));
   assign cnt_short  = (count_ff < CntW'(2));
   assign cnt_m1     = count_ff - CntW'(1);
   assign cnt_m2     = count_ff - CntW'(2);
   assign top_addr   = cnt_m1[AddrW-1:0];
   assign below_addr = cnt_m2[AddrW-1:0];
   assign idx_m1     = idx_ff - AddrW'(1);

   // Next state: walk the multi-cycle commands through their memory accesses.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.mode)
                  MODE_DUMP: if (!cnt_empty) state_in = ST_DUMP;
                  MODE_PEEK: if (!cnt_empty) state_in = ST_PEEK;
                  MODE_SWAP: if (!cnt_short) state_in = ST_SWAP_A;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PEEK:   state_in = ST_IDLE;
         ST_DUMP:   if (idx_ff == '0) state_in = ST_IDLE;
         ST_SWAP_A: state_in = ST_SWAP_B;
         ST_SWAP_B: state_in = ST_SWAP_C;
         ST_SWAP_C: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath: memory controls, count, result formation.
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      top_in        = top_ff;
      mem_raddr     = top_addr;
      mem_waddr     = count_ff[AddrW-1:0];
      mem_wdata     = req_item.push_value;
      mem_we        = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = '{out_value: '0, status: STATUS_OK, last: 1'b1};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.mode)
                  MODE_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (!req_item.arg_ok) begin
                        rsp_item_in.status = STATUS_BAD_ARG;
                     end else if (cnt_full) begin
                        rsp_item_in.status = STATUS_OVERFLOW;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  MODE_DUMP: begin
                     // Empty stack answers with a single zero; else start at the top.
                     rsp_strobe_in = cnt_empty;
                     idx_in        = top_addr;
                  end
                  MODE_PEEK: begin
                     rsp_strobe_in = cnt_empty;
                     rsp_item_in.status = STATUS_PEEK_EMPTY;
                  end
                  MODE_POP: begin
                     rsp_strobe_in = 1'b1;
                     if (cnt_empty) begin
                        rsp_item_in.status = STATUS_POP_EMPTY;
                     end else begin
                        count_in = cnt_m1;
                     end
                  end
                  MODE_SWAP: begin
                     rsp_strobe_in = cnt_short;
                     rsp_item_in.status = STATUS_SWAP_SHORT;
                  end
                  default: begin
                     rsp_strobe_in = 1'b0;
                  end
               endcase
            end
         end
         ST_PEEK: begin
            rsp_strobe_in         = 1'b1;
            rsp_item_in.out_value = rd_data_ff;
         end
         ST_DUMP: begin
            // Emit the entry read last cycle and fetch the one below it.
            rsp_strobe_in         = 1'b1;
            rsp_item_in.out_value = rd_data_ff;
            rsp_item_in.last      = (idx_ff == '0);
            mem_raddr             = idx_m1;
            idx_in                = idx_m1;
         end
         ST_SWAP_A: begin
            // Hold the top word, fetch the one below.
            top_in    = rd_data_ff;
            mem_raddr = below_addr;
         end
         ST_SWAP_B: begin
            mem_we    = 1'b1;
            mem_waddr = top_addr;
            mem_wdata = rd_data_ff;
         end
         ST_SWAP_C: begin
            mem_we        = 1'b1;
            mem_waddr     = below_addr;
            mem_wdata     = top_ff;
            rsp_strobe_in = 1'b1;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // Stack memory. The controller sequences swap so that both of its reads finish
   // before its writes; the read that overlaps the first swap write returns the old
   // word and is never used.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= stack_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      top_ff      <= top_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   `LSE_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CntW'(STACK_DEPTH), "entry count beyond depth")
   `LSE_ASSERT_NEXT(a_count_hold, state_ff != ST_IDLE, count_ff == $past(count_ff), "count moved while busy")
   `LSE_ASSERT_SAME(a_partial_dump, rsp_strobe_ff && !rsp_item_ff.last, state_ff == ST_DUMP, "non-final result outside dump")
   `LSE_ASSERT_NEXT(a_cmd_answer, accept && req_item.mode <= MODE_SWAP, rsp_strobe_ff || busy, "command left unanswered")

endmodule

// ===== dv/tb_lifo_stack_engine.sv =====
// Self-checking testbench for the LIFO stack engine: command stimulus and reply checking.
`timescale 1ns / 1ps

module tb_lifo_stack_engine;
   import lse_pkg::*;

   // Stack size of the instance below, which keeps the default parameter.
   localparam int DEPTH = STACK_DEPTH_DEF;

   // Mode codes that the engine must ignore: no reply, stack unchanged.
   localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
   localparam logic [2:0] MODE_SPARE_MID = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

   // Settle wait before the final verdict, longer than a full dump of DEPTH entries
   // needs to pass through the result register.
   localparam int SETTLE_CYCLES = DEPTH + 16;

   // Hard stop for a hung run, far beyond the slowest clean run.
   localparam longint RUN_LIMIT_NS = 64'd20_000_000;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Shadow copy of the stack, updated when a command transaction is accepted.
   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   int                       shadow_count = 0;

   // Replies the engine still owes, oldest first.
   rsp_type stack_replies [$];

   int fault_count     = 0;
   int sender_idle_pct = 0;

   lifo_stack_engine dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_lifo_stack_engine: done, errors");
      $finish;
   end

   // Apply one accepted command to the shadow stack and queue the replies it owes.
   function automatic void run_stack_command(input req_type cmd);
      rsp_type                  reply;
      logic signed [WORD_W-1:0] held;
      int                       pos;
      reply.out_value = '0;
      reply.status    = STATUS_OK;
      reply.last      = 1'b1;
      case (cmd.mode)
         MODE_PUSH: begin
            // A bad argument wins over a full stack.
            if (!cmd.arg_ok) begin
               reply.status = STATUS_BAD_ARG;
            end else if (shadow_count >= DEPTH) begin
               reply.status = STATUS_OVERFLOW;
            end else begin
               shadow_words[shadow_count] = cmd.push_value;
               shadow_count++;
            end
            stack_replies.push_back(reply);
         end
         MODE_DUMP: begin
            if (shadow_count == 0) begin
               stack_replies.push_back(reply);
            end else begin
               // Top entry first; only the bottom entry carries last.
               for (pos = shadow_count - 1; pos >= 0; pos--) begin
                  reply.out_value = shadow_words[pos];
                  reply.last      = (pos == 0);
                  stack_replies.push_back(reply);
               end
            end
         end
         MODE_PEEK: begin
            if (shadow_count == 0) reply.status = STATUS_PEEK_EMPTY;
            else reply.out_value = shadow_words[shadow_count - 1];
            stack_replies.push_back(reply);
         end
         MODE_POP: begin
            if (shadow_count == 0) reply.status = STATUS_POP_EMPTY;
            else shadow_count--;
            stack_replies.push_back(reply);
         end
         MODE_SWAP: begin
            if (shadow_count < 2) begin
               reply.status = STATUS_SWAP_SHORT;
            end else begin
               held                         = shadow_words[shadow_count - 1];
               shadow_words[shadow_count - 1] = shadow_words[shadow_count - 2];
               shadow_words[shadow_count - 2] = held;
            end
            stack_replies.push_back(reply);
         end
         default: ; // spare codes: drop silently
      endcase
   endfunction

   // Present one command and hold it until the engine takes it. Called right
   // after a rising edge; leaves start high so a following command goes
   // back to back without a gap.
   task automatic send_command(input logic [2:0] mode, input logic signed [WORD_W-1:0] value,
                               input logic ok);
      req_type cmd;
      cmd.mode       = mode;
      cmd.push_value = value;
      cmd.arg_ok     = ok;
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= cmd;
      // busy read here is the value before this edge's updates: the accept condition.
      do @(posedge clock); while (busy);
      run_stack_command(cmd);
   endtask

   // Word with extremes and small values mixed into plain random ones.
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return $urandom();
      endcase
   endfunction

   // Every command on an empty and a short stack, the word extremes and the
   // ignored mode codes.
   task automatic test_basic_commands();
      send_command(MODE_DUMP, 32'sd0, 1'b1);          // empty dump: one zero reply
      send_command(MODE_PEEK, 32'sd0, 1'b1);          // peek on empty
      send_command(MODE_POP,  32'sd0, 1'b1);          // pop on empty
      send_command(MODE_SWAP, 32'sd0, 1'b1);          // swap with no entries
      send_command(MODE_PUSH, $urandom(), 1'b0);      // bad argument on empty
      send_command(MODE_PUSH, 32'sh7FFF_FFFF, 1'b1);
      send_command(MODE_SWAP, 32'sd0, 1'b1);          // swap with one entry
      send_command(MODE_PUSH, 32'sh8000_0000, 1'b1);
      send_command(MODE_PEEK, 32'sd0, 1'b1);
      send_command(MODE_SWAP, $urandom(), 1'b0);      // value and arg_ok ignored
      send_command(MODE_PEEK, 32'sd0, 1'b1);
      send_command(MODE_DUMP, 32'sd0, 1'b1);
      send_command(MODE_SPARE_LO,  32'sh7FFF_FFFF, 1'b1);
      send_command(MODE_SPARE_MID, 32'sh8000_0000, 1'b0);
      send_command(MODE_SPARE_HI,  -32'sd1, 1'b1);
      send_command(MODE_PUSH, -32'sd1, 1'b1);
      send_command(MODE_PUSH, 32'sd0, 1'b1);
      send_command(MODE_DUMP, 32'sd0, 1'b1);
      repeat (4) send_command(MODE_POP, 32'sd0, 1'b1);
      send_command(MODE_POP,  32'sd0, 1'b1);          // one pop too many
      send_command(MODE_PUSH, 32'sd0, 1'b0);
      send_command(MODE_DUMP, 32'sd0, 1'b1);
   endtask

   // Fill the stack to the brim, hit overflow and the bad-argument-on-full
   // case, dump every entry, then drain it with peeks and swaps mixed in.
   task automatic test_full_stack();
      while (shadow_count < DEPTH) begin
         send_command(MODE_PUSH, pick_word(), $urandom_range(15) != 0);
      end
      send_command(MODE_PUSH, pick_word(), 1'b1);     // overflow
      send_command(MODE_PUSH, pick_word(), 1'b0);     // bad argument beats overflow
      send_command(MODE_PEEK, pick_word(), 1'b1);
      send_command(MODE_SWAP, pick_word(), 1'b1);
      send_command(MODE_DUMP, pick_word(), 1'b1);
      while (shadow_count > 0) begin
         case ($urandom_range(7))
            0:       send_command(MODE_PEEK, pick_word(), 1'b1);
            1:       send_command(MODE_SWAP, pick_word(), 1'b1);
            default: send_command(MODE_POP, pick_word(), 1'b1);
         endcase
      end
      send_command(MODE_POP,  pick_word(), 1'b1);
      send_command(MODE_DUMP, pick_word(), 1'b1);
   endtask

   // Batches of random commands; each batch draws its own push bias so the
   // depth wanders between empty and full.
   task automatic test_random_mix(input int batches);
      int          push_pct;
      int          roll;
      logic [2:0]  mode;
      repeat (batches) begin
         push_pct = $urandom_range(15, 85);
         repeat (25) begin
            roll = $urandom_range(99);
            if (roll < push_pct) begin
               mode = MODE_PUSH;
            end else begin
               roll = $urandom_range(99);
               if (roll < 4)       mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
               else if (roll < 20) mode = MODE_DUMP;
               else if (roll < 45) mode = MODE_PEEK;
               else if (roll < 75) mode = MODE_POP;
               else                mode = MODE_SWAP;
            end
            send_command(mode, pick_word(), $urandom_range(99) < 92);
         end
      end
   endtask

   // Compare each reply with the oldest one owed, field by field.
   always @(posedge clock) begin : reply_monitor
      rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (stack_replies.size() == 0) begin
            $display("%0t: stray reply: expected none, actual value %0d status %0d last %0b",
                     $time, rsp_item.out_value, rsp_item.status, rsp_item.last);
            fault_count++;
         end else begin
            want = stack_replies.pop_front();
            if (rsp_item.out_value !== want.out_value) begin
               $display("%0t: out_value: expected %0d, actual %0d",
                        $time, want.out_value, rsp_item.out_value);
               fault_count++;
            end
            if (rsp_item.status !== want.status) begin
               $display("%0t: status: expected %0d, actual %0d",
                        $time, want.status, rsp_item.status);
               fault_count++;
            end
            if (rsp_item.last !== want.last) begin
               $display("%0t: last: expected %0b, actual %0b",
                        $time, want.last, rsp_item.last);
               fault_count++;
            end
         end
      end
   end

   initial begin
      // Hold reset high from the start, then release it.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Light sender gaps first, then heavy gaps, then none at all.
      sender_idle_pct = 8;
      test_basic_commands();
      test_random_mix(4);
      sender_idle_pct = 72;
      test_full_stack();
      test_random_mix(4);
      sender_idle_pct = 0;
      test_random_mix(4);

      // Drop start once the last command is taken, drain what is owed,
      // then give any stray reply time to show up.
      start <= 1'b0;
      while (stack_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("tb_lifo_stack_engine: done, clean");
      end else begin
         $display("tb_lifo_stack_engine: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lse_pkg.sv
rtl/lifo_stack_engine.sv
dv/tb_lifo_stack_engine.sv
